[rtl/tmwc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwc_pkg
// Shared constants, codes and control structs of the weighted centroid unit.
// ----------------------------------------------------------------------------
package tmwc_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_VOLUME_SHIFT = 24;

    localparam int IDX_W   = 12;
    localparam int IN_W    = 18;
    localparam int CRD_W   = 19;
    localparam int VTX_W   = 3 * CRD_W;
    localparam int CEN_W   = 19;
    localparam int TOT_W   = 48;
    localparam int ACC_W   = 64;
    localparam int Q_STEPS = 19;

    localparam int S_DATA_W = 168;
    localparam int M_DATA_W = 112;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_TET    = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic       load_in;
        logic       wr_en;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       edge_en;
        logic       mul1_en;
        logic       mul2_en;
        logic       wgt_en;
        logic       mul3_en;
        logic       acc_en;
        logic       fin_start;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic corners_ok;
        logic empty;
    } status_t;

endpackage

[rtl/tmwc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwc_ctrl
// Sequencer: item intake, vertex reads, weight pipeline steps, division
// steps and output register handshake.
// ----------------------------------------------------------------------------
module tmwc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output tmwc_pkg::cmd_t   cmd,
    input  tmwc_pkg::status_t sts
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_READ   = 12'b000000000010,
        ST_WAIT   = 12'b000000000100,
        ST_EDGE   = 12'b000000001000,
        ST_MUL1   = 12'b000000010000,
        ST_MUL2   = 12'b000000100000,
        ST_WGT    = 12'b000001000000,
        ST_MUL3   = 12'b000010000000,
        ST_ACC    = 12'b000100000000,
        ST_FSTART = 12'b001000000000,
        ST_DIV    = 12'b010000000000,
        ST_FOUT   = 12'b100000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.rd_sel     = cnt_reg[1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_in = 1'b1;
                    case (s_tuser)
                        tmwc_pkg::FUNC_LOAD: cmd.wr_en = 1'b1;
                        tmwc_pkg::FUNC_TET: begin
                            if (sts.corners_ok) begin
                                state_next = ST_READ;
                                cnt_next   = '0;
                            end
                        end
                        tmwc_pkg::FUNC_FINISH: state_next = ST_FSTART;
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg[1:0] == 2'd3) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_EDGE;
            ST_EDGE: begin
                cmd.edge_en = 1'b1;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1_en = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2_en = 1'b1;
                state_next  = ST_WGT;
            end
            ST_WGT: begin
                cmd.wgt_en = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3_en = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_en = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FSTART: begin
                cmd.fin_start = 1'b1;
                cnt_next      = '0;
                state_next    = sts.empty ? ST_FOUT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(tmwc_pkg::Q_STEPS - 1)) begin
                    state_next = ST_FOUT;
                end
            end
            ST_FOUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/tmwc_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmwc_dp
// Datapath: vertex memory, determinant and weight pipeline, saturating
// accumulators, restoring divider and output register.
// ----------------------------------------------------------------------------
module tmwc_dp #(
    parameter int MAX_VERTICES = tmwc_pkg::DEF_MAX_VERTICES,
    parameter int VOLUME_SHIFT = tmwc_pkg::DEF_VOLUME_SHIFT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tmwc_pkg::cmd_t                     cmd,
    output tmwc_pkg::status_t                  sts,
    input  logic [tmwc_pkg::IDX_W-1:0]         vertex_index,
    input  logic signed [tmwc_pkg::IN_W-1:0]   rest_x,
    input  logic signed [tmwc_pkg::IN_W-1:0]   rest_y,
    input  logic signed [tmwc_pkg::IN_W-1:0]   rest_z,
    input  logic signed [tmwc_pkg::IN_W-1:0]   disp_x,
    input  logic signed [tmwc_pkg::IN_W-1:0]   disp_y,
    input  logic signed [tmwc_pkg::IN_W-1:0]   disp_z,
    input  logic [tmwc_pkg::IDX_W-1:0]         corner_a,
    input  logic [tmwc_pkg::IDX_W-1:0]         corner_b,
    input  logic [tmwc_pkg::IDX_W-1:0]         corner_c,
    input  logic [tmwc_pkg::IDX_W-1:0]         corner_d,
    output logic signed [tmwc_pkg::CEN_W-1:0]  centroid_x,
    output logic signed [tmwc_pkg::CEN_W-1:0]  centroid_y,
    output logic signed [tmwc_pkg::CEN_W-1:0]  centroid_z,
    output logic [tmwc_pkg::TOT_W-1:0]         total_weight,
    output logic                               empty_total,
    output logic                               saturated
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = tmwc_pkg::CRD_W;
    localparam int EW  = CW + 1;
    localparam int SW  = CW + 2;
    localparam int PW  = 2 * EW;
    localparam int TW  = PW + 1 + EW;
    localparam int DW  = TW + 2;
    localparam int MW  = 33 + SW;
    localparam int AC  = tmwc_pkg::ACC_W;
    localparam int DVW = tmwc_pkg::TOT_W + 2;
    localparam int DSW = DVW + tmwc_pkg::Q_STEPS - 1;
    localparam int QW  = tmwc_pkg::Q_STEPS;
    localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
    localparam logic signed [AC:0] ACC_MAX = {2'b00, {(AC-1){1'b1}}};
    localparam logic signed [AC:0] ACC_MIN = -ACC_MAX;
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    // vertex memory and read path
    logic [tmwc_pkg::VTX_W-1:0] vmem [MAX_VERTICES];
    logic [tmwc_pkg::VTX_W-1:0] rd_data_reg;
    logic                       cap_reg;
    logic [1:0]                 cap_sel_reg;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic                       idx_ok;
    logic [tmwc_pkg::IDX_W-1:0] cor_reg [4];
    logic [tmwc_pkg::IDX_W-1:0] rd_idx;
    logic signed [CW-1:0]       vx, vy, vz;

    assign idx_ok  = ({5'd0, vertex_index} < MAXV);
    assign wr_addr = AW'({5'd0, vertex_index});
    assign rd_idx  = cor_reg[cmd.rd_sel];
    assign rd_addr = AW'({5'd0, rd_idx});
    assign vx = CW'(rest_x) + CW'(disp_x);
    assign vy = CW'(rest_y) + CW'(disp_y);
    assign vz = CW'(rest_z) + CW'(disp_z);
    assign sts.corners_ok = ({5'd0, corner_a} < MAXV) && ({5'd0, corner_b} < MAXV)
                         && ({5'd0, corner_c} < MAXV) && ({5'd0, corner_d} < MAXV);

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && idx_ok) begin
            vmem[wr_addr] <= {vz, vy, vx};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= vmem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 1'b0;
        end else begin
            cap_reg <= cmd.rd_en;
        end
    end

    // corner latch and vertex capture
    logic signed [CW-1:0] px_reg [4];
    logic signed [CW-1:0] py_reg [4];
    logic signed [CW-1:0] pz_reg [4];

    always_ff @(posedge aclk) begin
        cap_sel_reg <= cmd.rd_sel;
        if (cmd.load_in) begin
            cor_reg[0] <= corner_a;
            cor_reg[1] <= corner_b;
            cor_reg[2] <= corner_c;
            cor_reg[3] <= corner_d;
        end
        if (cap_reg) begin
            px_reg[cap_sel_reg] <= rd_data_reg[CW-1:0];
            py_reg[cap_sel_reg] <= rd_data_reg[2*CW-1:CW];
            pz_reg[cap_sel_reg] <= rd_data_reg[3*CW-1:2*CW];
        end
    end

    // edge vectors and corner sums
    logic signed [EW-1:0] e1x_reg, e1y_reg, e1z_reg;
    logic signed [EW-1:0] e2x_reg, e2y_reg, e2z_reg;
    logic signed [EW-1:0] e3x_reg, e3y_reg, e3z_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;

    always_ff @(posedge aclk) begin
        if (cmd.edge_en) begin
            e1x_reg <= EW'(px_reg[1]) - EW'(px_reg[0]);
            e1y_reg <= EW'(py_reg[1]) - EW'(py_reg[0]);
            e1z_reg <= EW'(pz_reg[1]) - EW'(pz_reg[0]);
            e2x_reg <= EW'(px_reg[2]) - EW'(px_reg[0]);
            e2y_reg <= EW'(py_reg[2]) - EW'(py_reg[0]);
            e2z_reg <= EW'(pz_reg[2]) - EW'(pz_reg[0]);
            e3x_reg <= EW'(px_reg[3]) - EW'(px_reg[0]);
            e3y_reg <= EW'(py_reg[3]) - EW'(py_reg[0]);
            e3z_reg <= EW'(pz_reg[3]) - EW'(pz_reg[0]);
            sx_reg  <= SW'(px_reg[0]) + SW'(px_reg[1]) + SW'(px_reg[2]) + SW'(px_reg[3]);
            sy_reg  <= SW'(py_reg[0]) + SW'(py_reg[1]) + SW'(py_reg[2]) + SW'(py_reg[3]);
            sz_reg  <= SW'(pz_reg[0]) + SW'(pz_reg[1]) + SW'(pz_reg[2]) + SW'(pz_reg[3]);
        end
    end

    // cross products of the second and third edges
    logic signed [PW-1:0] ma_reg, mb_reg, mc_reg, md_reg, me_reg, mf_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul1_en) begin
            ma_reg <= e2y_reg * e3z_reg;
            mb_reg <= e2z_reg * e3y_reg;
            mc_reg <= e2z_reg * e3x_reg;
            md_reg <= e2x_reg * e3z_reg;
            me_reg <= e2x_reg * e3y_reg;
            mf_reg <= e2y_reg * e3x_reg;
        end
    end

    // first edge times cofactors
    logic signed [TW-1:0] t1_reg, t2_reg, t3_reg;
    logic signed [PW:0]   cof1, cof2, cof3;

    assign cof1 = (PW+1)'(ma_reg) - (PW+1)'(mb_reg);
    assign cof2 = (PW+1)'(mc_reg) - (PW+1)'(md_reg);
    assign cof3 = (PW+1)'(me_reg) - (PW+1)'(mf_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul2_en) begin
            t1_reg <= e1x_reg * cof1;
            t2_reg <= e1y_reg * cof2;
            t3_reg <= e1z_reg * cof3;
        end
    end

    // determinant magnitude, scaling and weight saturation
    logic signed [DW-1:0] det;
    logic [DW-1:0]        det_mag, mag_sh;
    logic [31:0]          w_reg;
    logic                 ovf_reg;
    logic                 w_sat;

    assign det     = DW'(t1_reg) + DW'(t2_reg) + DW'(t3_reg);
    assign det_mag = det[DW-1] ? DW'(-det) : DW'(det);
    assign mag_sh  = det_mag >> VOLUME_SHIFT;
    assign w_sat   = |mag_sh[DW-1:32];

    always_ff @(posedge aclk) begin
        if (cmd.wgt_en) begin
            w_reg <= w_sat ? 32'hFFFF_FFFF : mag_sh[31:0];
        end
    end

    // weight times corner sums
    logic signed [MW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [32:0]   w_s;

    assign w_s = $signed({1'b0, w_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul3_en) begin
            wx_reg <= w_s * sx_reg;
            wy_reg <= w_s * sy_reg;
            wz_reg <= w_s * sz_reg;
        end
    end

    // saturating accumulators
    logic signed [AC-1:0] accx_reg, accy_reg, accz_reg;
    logic [tmwc_pkg::TOT_W-1:0] tot_reg;
    logic signed [AC:0]   nx, ny, nz;
    logic signed [AC-1:0] cx_acc, cy_acc, cz_acc;
    logic                 fx, fy, fz;
    logic [tmwc_pkg::TOT_W:0] tsum;
    logic                 tsat;

    assign nx = (AC+1)'(accx_reg) + (AC+1)'(wx_reg);
    assign ny = (AC+1)'(accy_reg) + (AC+1)'(wy_reg);
    assign nz = (AC+1)'(accz_reg) + (AC+1)'(wz_reg);
    assign fx = (nx > ACC_MAX) || (nx < ACC_MIN);
    assign fy = (ny > ACC_MAX) || (ny < ACC_MIN);
    assign fz = (nz > ACC_MAX) || (nz < ACC_MIN);
    assign cx_acc = (nx > ACC_MAX) ? AC'(ACC_MAX) : (nx < ACC_MIN) ? AC'(ACC_MIN) : AC'(nx);
    assign cy_acc = (ny > ACC_MAX) ? AC'(ACC_MAX) : (ny < ACC_MIN) ? AC'(ACC_MIN) : AC'(ny);
    assign cz_acc = (nz > ACC_MAX) ? AC'(ACC_MAX) : (nz < ACC_MIN) ? AC'(ACC_MIN) : AC'(nz);
    assign tsum = {1'b0, tot_reg} + (tmwc_pkg::TOT_W+1)'(w_reg);
    assign tsat = tsum[tmwc_pkg::TOT_W];
    assign sts.empty = (tot_reg == '0);

    // divider state
    logic [AC-1:0]  remx_reg, remy_reg, remz_reg;
    logic [DSW-1:0] dsh_reg;
    logic [QW-1:0]  qx_reg, qy_reg, qz_reg;
    logic           negx_reg, negy_reg, negz_reg;
    logic           gx, gy, gz;

    assign gx = ({{(DSW-AC){1'b0}}, remx_reg} >= dsh_reg);
    assign gy = ({{(DSW-AC){1'b0}}, remy_reg} >= dsh_reg);
    assign gz = ({{(DSW-AC){1'b0}}, remz_reg} >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (cmd.fin_start) begin
            dsh_reg  <= DSW'({tot_reg, 2'b00}) << (QW - 1);
            negx_reg <= accx_reg[AC-1];
            negy_reg <= accy_reg[AC-1];
            negz_reg <= accz_reg[AC-1];
            remx_reg <= accx_reg[AC-1] ? AC'(-accx_reg) : AC'(accx_reg);
            remy_reg <= accy_reg[AC-1] ? AC'(-accy_reg) : AC'(accy_reg);
            remz_reg <= accz_reg[AC-1] ? AC'(-accz_reg) : AC'(accz_reg);
            qx_reg   <= '0;
            qy_reg   <= '0;
            qz_reg   <= '0;
        end else if (cmd.div_step) begin
            dsh_reg <= dsh_reg >> 1;
            if (gx) begin
                remx_reg <= remx_reg - AC'(dsh_reg);
            end
            if (gy) begin
                remy_reg <= remy_reg - AC'(dsh_reg);
            end
            if (gz) begin
                remz_reg <= remz_reg - AC'(dsh_reg);
            end
            qx_reg <= {qx_reg[QW-2:0], gx};
            qy_reg <= {qy_reg[QW-2:0], gy};
            qz_reg <= {qz_reg[QW-2:0], gz};
        end
    end

    // centroid clamping; a top quotient bit means the quotient is out of range
    logic signed [CW-1:0] rx, ry, rz;
    logic                 clx, cly, clz;

    assign rx  = qx_reg[QW-1] ? (negx_reg ? C_MIN : C_MAX)
                              : (negx_reg ? -$signed(qx_reg) : $signed(qx_reg));
    assign ry  = qy_reg[QW-1] ? (negy_reg ? C_MIN : C_MAX)
                              : (negy_reg ? -$signed(qy_reg) : $signed(qy_reg));
    assign rz  = qz_reg[QW-1] ? (negz_reg ? C_MIN : C_MAX)
                              : (negz_reg ? -$signed(qz_reg) : $signed(qz_reg));
    assign clx = qx_reg[QW-1] && !negx_reg;
    assign cly = qy_reg[QW-1] && !negy_reg;
    assign clz = qz_reg[QW-1] && !negz_reg;

    // accumulator update and clear on finish
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
            tot_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (cmd.out_load) begin
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
            tot_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            if (cmd.wgt_en && w_sat) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.acc_en) begin
                accx_reg <= cx_acc;
                accy_reg <= cy_acc;
                accz_reg <= cz_acc;
                tot_reg  <= tsat ? {tmwc_pkg::TOT_W{1'b1}} : tsum[tmwc_pkg::TOT_W-1:0];
                if (fx || fy || fz || tsat) begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            total_weight <= tot_reg;
            empty_total  <= sts.empty;
            if (sts.empty) begin
                centroid_x <= '0;
                centroid_y <= '0;
                centroid_z <= '0;
                saturated  <= ovf_reg;
            end else begin
                centroid_x <= rx;
                centroid_y <= ry;
                centroid_z <= rz;
                saturated  <= ovf_reg || clx || cly || clz;
            end
        end
    end

endmodule

[rtl/tet_mesh_weighted_centroid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tet_mesh_weighted_centroid_unit
// Volume-weighted centroid of a displaced tetrahedral mesh frame.
// ----------------------------------------------------------------------------
// One item is taken at a time. A load item writes the vertex memory. A
// tetrahedron item passes through intake, four reads from the single read
// port of the vertex memory, a wait for the last read to be captured, then
// edge, two multiply, weight, multiply and accumulate steps. A finish item
// passes through intake, a setup step, 19 divider steps and the output
// load, and skips the divider steps when the total weight is zero; the
// three centroid quotients come from a restoring divider that retires one
// quotient bit per cycle. Items with an out-of-range corner, or kind 3,
// change nothing. The result waits in an output register; a finish only
// stalls if that register is still full when its own result is ready.
// ----------------------------------------------------------------------------
module tet_mesh_weighted_centroid_unit #(
    parameter int MAX_VERTICES = tmwc_pkg::DEF_MAX_VERTICES,
    parameter int VOLUME_SHIFT = tmwc_pkg::DEF_VOLUME_SHIFT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // vertex_index, rest_x, rest_y, rest_z, disp_x, disp_y, disp_z,
    // corner_a, corner_b, corner_c, corner_d
    input  logic [tmwc_pkg::S_DATA_W-1:0] s_tdata,
    // func
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // centroid_x, centroid_y, centroid_z, total_weight, zero pad
    output logic [tmwc_pkg::M_DATA_W-1:0] m_tdata,
    // empty_total, saturated
    output logic [1:0]                    m_tuser
);

    tmwc_pkg::cmd_t    cmd;
    tmwc_pkg::status_t sts;

    logic signed [tmwc_pkg::CEN_W-1:0] cx, cy, cz;
    logic [tmwc_pkg::TOT_W-1:0]        tot;
    logic                              empty, sat;

    tmwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tmwc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .VOLUME_SHIFT (VOLUME_SHIFT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .vertex_index (s_tdata[11:0]),
        .rest_x       (s_tdata[29:12]),
        .rest_y       (s_tdata[47:30]),
        .rest_z       (s_tdata[65:48]),
        .disp_x       (s_tdata[83:66]),
        .disp_y       (s_tdata[101:84]),
        .disp_z       (s_tdata[119:102]),
        .corner_a     (s_tdata[131:120]),
        .corner_b     (s_tdata[143:132]),
        .corner_c     (s_tdata[155:144]),
        .corner_d     (s_tdata[167:156]),
        .centroid_x   (cx),
        .centroid_y   (cy),
        .centroid_z   (cz),
        .total_weight (tot),
        .empty_total  (empty),
        .saturated    (sat)
    );

    // result packing
    assign m_tdata = {7'd0, tot, cz, cy, cx};
    assign m_tuser = {sat, empty};

endmodule

[tb/tb_tet_mesh_weighted_centroid_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tet_mesh_weighted_centroid_unit
// Self-checking bench for the volume-weighted tetrahedral centroid unit.
// Vertex loads, tetrahedra and frame finishes are pushed through the input
// stream with random gaps; a behavioral centroid calculator predicts every
// finish result and the monitor compares each output item field by field.
// ----------------------------------------------------------------------------
module tb_tet_mesh_weighted_centroid_unit;

    localparam int NVERT   = tmwc_pkg::DEF_MAX_VERTICES;
    localparam int VSHIFT  = tmwc_pkg::DEF_VOLUME_SHIFT;
    localparam int NLOADED = 64;

    typedef struct packed {
        logic [tmwc_pkg::IDX_W-1:0] corner_d;
        logic [tmwc_pkg::IDX_W-1:0] corner_c;
        logic [tmwc_pkg::IDX_W-1:0] corner_b;
        logic [tmwc_pkg::IDX_W-1:0] corner_a;
        logic [tmwc_pkg::IN_W-1:0]  disp_z;
        logic [tmwc_pkg::IN_W-1:0]  disp_y;
        logic [tmwc_pkg::IN_W-1:0]  disp_x;
        logic [tmwc_pkg::IN_W-1:0]  rest_z;
        logic [tmwc_pkg::IN_W-1:0]  rest_y;
        logic [tmwc_pkg::IN_W-1:0]  rest_x;
        logic [tmwc_pkg::IDX_W-1:0] vertex_index;
    } mesh_fields_t;

    typedef struct {
        tmwc_pkg::func_t func;
        mesh_fields_t    f;
    } mesh_item_t;

    typedef struct {
        logic [tmwc_pkg::CEN_W-1:0] cx, cy, cz;
        logic [tmwc_pkg::TOT_W-1:0] total;
        logic                       empty_total, saturated;
    } centroid_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [tmwc_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [tmwc_pkg::M_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    tet_mesh_weighted_centroid_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #2 aclk = ~aclk;

    // predictor state
    longint          vtx_x [NVERT];
    longint          vtx_y [NVERT];
    longint          vtx_z [NVERT];
    longint          sum_x, sum_y, sum_z;
    longint unsigned wtotal;
    bit              ovf;

    mesh_item_t pending_items[$];
    centroid_t  expected_centroids[$];
    int         errors = 0;
    int         n_loads = 0, n_tets = 0, n_finishes = 0, n_checked = 0;
    bit         stim_done = 1'b0;

    localparam longint ACC_LIM = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned TOT_LIM = 64'hFFFF_FFFF_FFFF;

    function automatic void queue_item(mesh_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic longint sadd(longint acc, longint t);
        if (t > 0 && acc > ACC_LIM - t) begin
            ovf = 1'b1;
            return ACC_LIM;
        end
        if (t < 0 && acc < -ACC_LIM - t) begin
            ovf = 1'b1;
            return -ACC_LIM;
        end
        return acc + t;
    endfunction

    function automatic logic [tmwc_pkg::CEN_W-1:0] quotient(longint s, longint unsigned dv);
        longint unsigned mag, q;
        longint r;
        mag = (s < 0) ? 64'd0 - longint'(s) : s;
        q = mag / dv;
        if (q > 262144) q = 262144;
        r = (s < 0) ? -longint'(q) : longint'(q);
        if (r > 262143) begin
            ovf = 1'b1;
            r = 262143;
        end
        if (r < -262144) begin
            ovf = 1'b1;
            r = -262144;
        end
        return r[tmwc_pkg::CEN_W-1:0];
    endfunction

    // apply one accepted item to the predictor
    task automatic predict_centroid(mesh_item_t it);
        longint px[4], py[4], pz[4];
        int k[4];
        longint e1x, e1y, e1z, e2x, e2y, e2z, e3x, e3y, e3z, det;
        longint unsigned mag, w;
        centroid_t c;
        case (it.func)
            tmwc_pkg::FUNC_LOAD: begin
                k[0] = it.f.vertex_index;
                vtx_x[k[0]] = longint'($signed(it.f.rest_x)) + longint'($signed(it.f.disp_x));
                vtx_y[k[0]] = longint'($signed(it.f.rest_y)) + longint'($signed(it.f.disp_y));
                vtx_z[k[0]] = longint'($signed(it.f.rest_z)) + longint'($signed(it.f.disp_z));
                n_loads++;
            end
            tmwc_pkg::FUNC_TET: begin
                k[0] = it.f.corner_a; k[1] = it.f.corner_b;
                k[2] = it.f.corner_c; k[3] = it.f.corner_d;
                for (int i = 0; i < 4; i++) begin
                    px[i] = vtx_x[k[i]]; py[i] = vtx_y[k[i]]; pz[i] = vtx_z[k[i]];
                end
                e1x = px[1] - px[0]; e1y = py[1] - py[0]; e1z = pz[1] - pz[0];
                e2x = px[2] - px[0]; e2y = py[2] - py[0]; e2z = pz[2] - pz[0];
                e3x = px[3] - px[0]; e3y = py[3] - py[0]; e3z = pz[3] - pz[0];
                det = e1x * (e2y * e3z - e2z * e3y) + e1y * (e2z * e3x - e2x * e3z)
                    + e1z * (e2x * e3y - e2y * e3x);
                mag = (det < 0) ? longint'(-det) : det;
                w = mag >> VSHIFT;
                if (w > 64'hFFFF_FFFF) begin
                    w = 64'hFFFF_FFFF;
                    ovf = 1'b1;
                end
                sum_x = sadd(sum_x, longint'(w) * (px[0] + px[1] + px[2] + px[3]));
                sum_y = sadd(sum_y, longint'(w) * (py[0] + py[1] + py[2] + py[3]));
                sum_z = sadd(sum_z, longint'(w) * (pz[0] + pz[1] + pz[2] + pz[3]));
                if (wtotal > TOT_LIM - w) begin
                    wtotal = TOT_LIM;
                    ovf = 1'b1;
                end else begin
                    wtotal += w;
                end
                n_tets++;
            end
            tmwc_pkg::FUNC_FINISH: begin
                c.empty_total = (wtotal == 0);
                c.cx = '0; c.cy = '0; c.cz = '0;
                if (!c.empty_total) begin
                    c.cx = quotient(sum_x, wtotal * 4);
                    c.cy = quotient(sum_y, wtotal * 4);
                    c.cz = quotient(sum_z, wtotal * 4);
                end
                c.total = wtotal[tmwc_pkg::TOT_W-1:0];
                c.saturated = ovf;
                expected_centroids = {expected_centroids, c};
                sum_x = 0; sum_y = 0; sum_z = 0; wtotal = 0; ovf = 1'b0;
                n_finishes++;
            end
            default: ;
        endcase
    endtask

    function automatic logic [tmwc_pkg::IN_W-1:0] rnd_coord(int mode);
        case (mode)
            0: return 18'h1FFFF;
            1: return 18'h20000;
            2: return tmwc_pkg::IN_W'($urandom_range(0, 2047) - 1024);
            default: return tmwc_pkg::IN_W'($urandom);
        endcase
    endfunction

    function automatic mesh_item_t mk_load(int idx, int mode);
        mesh_item_t it;
        it.func = tmwc_pkg::FUNC_LOAD;
        it.f = mesh_fields_t'(tmwc_pkg::S_DATA_W'({$urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom}));
        it.f.vertex_index = tmwc_pkg::IDX_W'(idx);
        it.f.rest_x = rnd_coord(mode); it.f.rest_y = rnd_coord(mode);
        it.f.rest_z = rnd_coord(mode); it.f.disp_x = rnd_coord(mode);
        it.f.disp_y = rnd_coord(mode); it.f.disp_z = rnd_coord(mode);
        return it;
    endfunction

    function automatic mesh_item_t mk_tet(int a, int b, int c, int d);
        mesh_item_t it;
        it.func = tmwc_pkg::FUNC_TET;
        it.f = mesh_fields_t'(tmwc_pkg::S_DATA_W'({$urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom}));
        it.f.corner_a = tmwc_pkg::IDX_W'(a); it.f.corner_b = tmwc_pkg::IDX_W'(b);
        it.f.corner_c = tmwc_pkg::IDX_W'(c); it.f.corner_d = tmwc_pkg::IDX_W'(d);
        return it;
    endfunction

    function automatic mesh_item_t mk_kind(tmwc_pkg::func_t fn);
        mesh_item_t it;
        it.func = fn;
        it.f = mesh_fields_t'(tmwc_pkg::S_DATA_W'({$urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom}));
        return it;
    endfunction

    function automatic int rnd_slot();
        return ($urandom_range(0, 7) == 0) ? NVERT - 1 - $urandom_range(0, 3)
                                           : $urandom_range(0, NLOADED - 1);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // stimulus plan
    initial begin
        // directed: extremes at the top slots, a random tet, degenerate, empty frame
        queue_item(mk_kind(tmwc_pkg::FUNC_FINISH));
        queue_item(mk_load(NVERT - 1, 0));
        queue_item(mk_load(NVERT - 2, 1));
        queue_item(mk_load(NVERT - 3, 0));
        queue_item(mk_load(NVERT - 4, 1));
        queue_item(mk_tet(NVERT - 1, NVERT - 2, NVERT - 3, NVERT - 4));
        queue_item(mk_kind(tmwc_pkg::FUNC_FINISH));
        queue_item(mk_load(0, 3));
        queue_item(mk_load(1, 3));
        queue_item(mk_load(2, 3));
        queue_item(mk_load(3, 3));
        queue_item(mk_tet(0, 1, 2, 3));
        queue_item(mk_tet(0, 0, 1, 2));
        queue_item(mk_kind(tmwc_pkg::FUNC_NONE));
        queue_item(mk_tet(3, 2, 1, 0));
        queue_item(mk_kind(tmwc_pkg::FUNC_FINISH));
        for (int i = 4; i < NLOADED; i++) queue_item(mk_load(i, 3));
        // random frames of loads and tets, some degenerate, with some noise
        while (pending_items.size() < 1150) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 12) queue_item(mk_load(rnd_slot(), $urandom_range(0, 3)));
            else if (r < 80)
                queue_item(mk_tet(rnd_slot(), rnd_slot(), rnd_slot(), rnd_slot()));
            else if (r < 96) queue_item(mk_kind(tmwc_pkg::FUNC_FINISH));
            else queue_item(mk_kind(tmwc_pkg::FUNC_NONE));
        end
        queue_item(mk_kind(tmwc_pkg::FUNC_FINISH));
    end

    // input acceptance caught at the rising edge, used by the driver at the falling edge
    bit acc_seen = 1'b0;
    always @(posedge aclk) acc_seen <= s_tvalid && s_tready;

    // driver
    int drv_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (acc_seen) begin
                predict_centroid(pending_items.pop_front());
                drv_gap = gap_len();
            end
            if (s_tvalid && !acc_seen) begin
                // hold current item
            end else if (drv_gap > 0 || pending_items.size() == 0) begin
                if (drv_gap > 0) drv_gap--;
                s_tvalid <= 1'b0;
                if (pending_items.size() == 0) stim_done = 1'b1;
            end else begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].func;
                s_tdata  <= tmwc_pkg::S_DATA_W'(pending_items[0].f);
            end
        end
    end

    // monitor and ready pattern
    int rdy_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rdy_gap > 0) begin
                rdy_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rdy_gap = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        centroid_t c;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_centroids.size() == 0) begin
                $display("%0t: unexpected result, expected none, got data=%h user=%b",
                         $realtime, m_tdata, m_tuser);
                errors++;
            end else begin
                c = expected_centroids.pop_front();
                n_checked++;
                if (m_tdata[18:0] !== c.cx) begin
                    $display("%0t: centroid_x exp %h got %h", $realtime, c.cx, m_tdata[18:0]);
                    errors++;
                end
                if (m_tdata[37:19] !== c.cy) begin
                    $display("%0t: centroid_y exp %h got %h", $realtime, c.cy, m_tdata[37:19]);
                    errors++;
                end
                if (m_tdata[56:38] !== c.cz) begin
                    $display("%0t: centroid_z exp %h got %h", $realtime, c.cz, m_tdata[56:38]);
                    errors++;
                end
                if (m_tdata[104:57] !== c.total) begin
                    $display("%0t: total_weight exp %h got %h", $realtime, c.total,
                             m_tdata[104:57]);
                    errors++;
                end
                if (m_tuser[0] !== c.empty_total) begin
                    $display("%0t: empty_total exp %b got %b", $realtime, c.empty_total,
                             m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== c.saturated) begin
                    $display("%0t: saturated exp %b got %b", $realtime, c.saturated,
                             m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // reset, then wait for the end of traffic
    initial begin
        sum_x = 0; sum_y = 0; sum_z = 0; wtotal = 0; ovf = 1'b0;
        foreach (vtx_x[i]) begin
            vtx_x[i] = 0; vtx_y[i] = 0; vtx_z[i] = 0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        wait (stim_done && expected_centroids.size() == 0);
        repeat (100) @(posedge aclk);
        $display("covered %0d loads, %0d tetrahedra, %0d frame finishes; %0d results checked",
                 n_loads, n_tets, n_finishes, n_checked);
        if (errors == 0 && expected_centroids.size() == 0)
            $display("tet_mesh_weighted_centroid_unit: match");
        else
            $display("tet_mesh_weighted_centroid_unit: mismatch");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tet_mesh_weighted_centroid_unit: mismatch");
        $finish;
    end

endmodule

[tet_mesh_weighted_centroid_unit.f]
rtl/tmwc_pkg.sv
rtl/tmwc_ctrl.sv
rtl/tmwc_dp.sv
rtl/tet_mesh_weighted_centroid_unit.sv
tb/tb_tet_mesh_weighted_centroid_unit.sv
